// File: src/tes_pkg.sv
// Shared types, constants and exponential tables for the throttle smoother.
package tes_pkg;

    localparam int LIMIT           = 1500;
    localparam int EXP_INT_MAX     = 12;
    localparam int DIV_STEPS       = 32;
    localparam int MUL_STEPS       = 17;
    localparam int CNT_W           = 5;

    localparam logic [16:0] ALPHA_ONE      = 17'd65536;
    localparam logic [16:0] ALPHA_FALLBACK = 17'd1311;
    localparam logic [16:0] ALPHA_FLOOR    = 17'd433;
    localparam logic [15:0] SMOOTHING_RESET = 16'd100;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic div_init;
        logic div_step;
        logic exp_seg;
        logic exp_mul;
        logic alpha_set;
        logic mul_init;
        logic mul_step;
        logic update;
        logic clear;
        logic out_write;
    } tes_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic both_present;
        logic tc_zero;
    } tes_sts_t;

    // round(e^-(k/16) * 2^16), k = 0..16
    function automatic logic [16:0] exp_frac(input logic [4:0] k);
        logic [16:0] v;
        unique case (k)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd61565;
            5'd2:    v = 17'd57835;
            5'd3:    v = 17'd54331;
            5'd4:    v = 17'd51039;
            5'd5:    v = 17'd47947;
            5'd6:    v = 17'd45042;
            5'd7:    v = 17'd42313;
            5'd8:    v = 17'd39750;
            5'd9:    v = 17'd37341;
            5'd10:   v = 17'd35079;
            5'd11:   v = 17'd32954;
            5'd12:   v = 17'd30957;
            5'd13:   v = 17'd29081;
            5'd14:   v = 17'd27319;
            5'd15:   v = 17'd25664;
            5'd16:   v = 17'd24109;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    // round(e^-i * 2^16), i = 0..11
    function automatic logic [16:0] exp_int(input logic [3:0] i);
        logic [16:0] v;
        unique case (i)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd24109;
            4'd2:    v = 17'd8869;
            4'd3:    v = 17'd3263;
            4'd4:    v = 17'd1200;
            4'd5:    v = 17'd442;
            4'd6:    v = 17'd162;
            4'd7:    v = 17'd60;
            4'd8:    v = 17'd22;
            4'd9:    v = 17'd8;
            4'd10:   v = 17'd3;
            4'd11:   v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage

// File: src/tes_dpath.sv
// Datapath: config register, divider, exponential, blend multiplier and filter state.
module tes_dpath #(
    parameter int FRAC_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [15:0]           cfg_smoothing_ms,
    input  logic                  s_gas_present,
    input  logic [9:0]            s_gas_level,
    input  logic                  s_brake_present,
    input  logic [9:0]            s_brake_level,
    input  logic [15:0]           s_elapsed_ms,
    input  tes_pkg::tes_cmd_t     cmd,
    output tes_pkg::tes_sts_t     sts,
    output logic signed [11:0]    m_drive_pwm,
    output logic                  m_active
);

    localparam int SW = FRAC_BITS + 12;   // state width
    localparam int DW = FRAC_BITS + 13;   // difference width
    localparam int AW = FRAC_BITS + 29;   // product accumulator width
    localparam logic signed [DW:0] LIM_POS =
        $signed((DW+1)'(tes_pkg::LIMIT) << FRAC_BITS);
    localparam logic signed [DW:0] LIM_NEG = -LIM_POS;

    logic [15:0]          smoothing_reg, smoothing_next;
    logic                 gp_reg, bp_reg;
    logic [9:0]           gas_reg, brake_reg;
    logic [15:0]          elapsed_reg;
    logic [16:0]          rem_reg;
    logic [31:0]          quo_reg;
    logic [3:0]           ip_reg;
    logic [16:0]          ef_reg;
    logic                 sat_reg;
    logic [16:0]          alpha_reg;
    logic [AW-1:0]        mcand_reg, acc_reg;
    logic [16:0]          mplier_reg;
    logic                 neg_reg;
    logic signed [SW-1:0] sv_reg, sv_next;
    logic signed [11:0]   drive_reg;
    logic                 active_reg;

    // divider step
    logic [16:0] rem_sh, rem_sub;
    logic        div_ge;
    // exponential
    logic        sat;
    logic [3:0]  seg;
    logic [16:0] tab_a, tab_b, tab_d;
    logic [23:0] ip_prod;
    logic [16:0] ef;
    logic [33:0] e_prod;
    logic [34:0] e_sum;
    logic [16:0] expv, alpha_raw, alpha_fl;
    // control input and difference
    logic signed [11:0]   dsb;
    logic signed [13:0]   d3;
    logic                 in_range;
    logic signed [SW-1:0] u;
    logic signed [DW-1:0] diff;
    logic [DW-1:0]        diff_mag;
    // update
    logic [DW-1:0]        step_mag;
    logic signed [DW-1:0] step_s;
    logic signed [DW:0]   sum;
    logic signed [DW:0]   clamped;
    // output
    logic [SW-1:0]        sv_abs;
    logic [11:0]          drv_mag;

    assign sts.both_present = gp_reg & bp_reg;
    assign sts.tc_zero      = (smoothing_reg == 16'd0);

    assign smoothing_next = cfg_we ? cfg_smoothing_ms : smoothing_reg;

    always_comb begin
        rem_sh  = {rem_reg[15:0], quo_reg[31]};
        div_ge  = (rem_sh >= {1'b0, smoothing_reg});
        rem_sub = rem_sh - {1'b0, smoothing_reg};
    end

    always_comb begin
        sat     = (quo_reg[31:20] != 12'd0) || (quo_reg[19:16] >= 4'(tes_pkg::EXP_INT_MAX));
        seg     = quo_reg[15:12];
        tab_a   = tes_pkg::exp_frac({1'b0, seg});
        tab_b   = tes_pkg::exp_frac({1'b0, seg} + 5'd1);
        tab_d   = tab_a - tab_b;
        ip_prod = {12'd0, tab_d[11:0]} * {12'd0, quo_reg[11:0]};
        ef      = tab_a - {5'd0, 12'((ip_prod + 24'd2048) >> 12)};
    end

    always_comb begin
        e_prod    = {17'd0, tes_pkg::exp_int(ip_reg)} * {17'd0, ef_reg};
        e_sum     = {1'b0, e_prod} + 35'd32768;
        expv      = e_sum[32:16];
        alpha_raw = sat_reg ? tes_pkg::ALPHA_ONE : (tes_pkg::ALPHA_ONE - expv);
        alpha_fl  = (alpha_raw < tes_pkg::ALPHA_FLOOR) ? tes_pkg::ALPHA_FLOOR : alpha_raw;
    end

    // u = 1.5 * (gas - brake) in state format, zero when out of range
    always_comb begin
        dsb      = $signed({2'b00, gas_reg}) - $signed({2'b00, brake_reg});
        d3       = 14'(dsb) + 14'(dsb) + 14'(dsb);
        in_range = (d3 <= 14'sd3000) && (d3 >= -14'sd3000);
        u        = in_range ? ($signed({{(SW-14){d3[13]}}, d3}) <<< (FRAC_BITS - 1))
                            : '0;
        diff     = $signed({u[SW-1], u}) - $signed({sv_reg[SW-1], sv_reg});
        diff_mag = diff[DW-1] ? DW'(-diff) : DW'(diff);
    end

    always_comb begin
        step_mag = acc_reg[AW-1:16];
        step_s   = neg_reg ? -$signed(step_mag) : $signed(step_mag);
        sum      = $signed({{2{sv_reg[SW-1]}}, sv_reg}) + $signed({step_s[DW-1], step_s});
        if (sum > LIM_POS) begin
            clamped = LIM_POS;
        end else if (sum < LIM_NEG) begin
            clamped = LIM_NEG;
        end else begin
            clamped = sum;
        end
    end

    always_comb begin
        sv_abs  = sv_reg[SW-1] ? SW'(-sv_reg) : SW'(sv_reg);
        drv_mag = sv_abs[SW-1:FRAC_BITS];
    end

    always_comb begin
        sv_next = sv_reg;
        if (cmd.clear) begin
            sv_next = '0;
        end else if (cmd.update) begin
            sv_next = clamped[SW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            smoothing_reg <= tes_pkg::SMOOTHING_RESET;
            sv_reg        <= '0;
        end else begin
            smoothing_reg <= smoothing_next;
            sv_reg        <= sv_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            gp_reg      <= s_gas_present;
            bp_reg      <= s_brake_present;
            gas_reg     <= s_gas_level;
            brake_reg   <= s_brake_level;
            elapsed_reg <= s_elapsed_ms;
        end
        if (cmd.div_init) begin
            rem_reg <= '0;
            quo_reg <= {elapsed_reg, 16'd0};
        end else if (cmd.div_step) begin
            rem_reg <= div_ge ? rem_sub : rem_sh;
            quo_reg <= {quo_reg[30:0], div_ge};
        end
        if (cmd.exp_seg) begin
            sat_reg <= sat;
            ip_reg  <= quo_reg[19:16];
            ef_reg  <= ef;
        end
        if (cmd.alpha_set) begin
            alpha_reg <= (elapsed_reg == 16'd0) ? tes_pkg::ALPHA_FALLBACK
                                                : tes_pkg::ALPHA_ONE;
        end else if (cmd.exp_mul) begin
            alpha_reg <= alpha_fl;
        end
        if (cmd.mul_init) begin
            mcand_reg  <= {{(AW-DW){1'b0}}, diff_mag};
            mplier_reg <= alpha_reg;
            acc_reg    <= '0;
            neg_reg    <= diff[DW-1];
        end else if (cmd.mul_step) begin
            if (mplier_reg[0]) begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= {mcand_reg[AW-2:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[16:1]};
        end
        if (cmd.out_write) begin
            drive_reg  <= sv_reg[SW-1] ? -$signed(drv_mag) : $signed(drv_mag);
            active_reg <= gp_reg & bp_reg;
        end
    end

    assign m_drive_pwm = drive_reg;
    assign m_active    = active_reg;

endmodule

// File: src/tes_ctrl.sv
// Controller: sequences one update through the datapath and owns the handshakes.
module tes_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  tes_pkg::tes_sts_t  sts,
    output tes_pkg::tes_cmd_t  cmd
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_DECIDE  = 4'd1;
    localparam logic [3:0] ST_DIV     = 4'd2;
    localparam logic [3:0] ST_EXP_SEG = 4'd3;
    localparam logic [3:0] ST_EXP_MUL = 4'd4;
    localparam logic [3:0] ST_MPREP   = 4'd5;
    localparam logic [3:0] ST_MULT    = 4'd6;
    localparam logic [3:0] ST_UPD     = 4'd7;
    localparam logic [3:0] ST_DONE    = 4'd8;

    logic [3:0]                 state_reg, state_next;
    logic [tes_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic                       m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                priority if (!sts.both_present) begin
                    cmd.clear  = 1'b1;
                    state_next = ST_DONE;
                end else if (sts.tc_zero) begin
                    cmd.alpha_set = 1'b1;
                    state_next    = ST_MPREP;
                end else begin
                    cmd.div_init = 1'b1;
                    cnt_next     = '0;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == tes_pkg::CNT_W'(tes_pkg::DIV_STEPS - 1)) begin
                    state_next = ST_EXP_SEG;
                end
            end
            ST_EXP_SEG: begin
                cmd.exp_seg = 1'b1;
                state_next  = ST_EXP_MUL;
            end
            ST_EXP_MUL: begin
                cmd.exp_mul = 1'b1;
                state_next  = ST_MPREP;
            end
            ST_MPREP: begin
                cmd.mul_init = 1'b1;
                cnt_next     = '0;
                state_next   = ST_MULT;
            end
            ST_MULT: begin
                cmd.mul_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == tes_pkg::CNT_W'(tes_pkg::MUL_STEPS - 1)) begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD: begin
                cmd.update = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_write = 1'b1;
                    m_valid_next  = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

`ifndef ASSERT_OFF
    a_accept_to_decide: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == ST_DECIDE)
        else $error("accepted beat did not enter decide");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_write |-> !m_valid_reg || m_ready)
        else $error("result register overwritten while held");

    a_div_length: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV && cnt_reg == tes_pkg::CNT_W'(tes_pkg::DIV_STEPS - 1)
        |=> state_reg == ST_EXP_SEG)
        else $error("divider did not finish after its step count");

    a_mul_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_MULT |-> cnt_reg < tes_pkg::CNT_W'(tes_pkg::MUL_STEPS))
        else $error("multiplier step counter overran");
`endif

endmodule

// File: src/throttle_exponential_smoother.sv
// Top level of the throttle exponential smoother.
// Each input beat is one pedal update; each produces exactly one result beat.
// With both readings present the block runs alpha = 1 - exp(-elapsed/smoothing)
// and blends 1.5*(gas - brake) into its FRAC_BITS fixed-point state; with a
// reading missing the state clears and the result is 0 with active low.
// Sequence: a full update runs the bit-serial divider, one quotient bit per
// step, then the shift-add blend multiplier, one alpha bit per step. With a
// zero time constant the divider is skipped; with a missing reading both are
// skipped. The next beat is taken in the idle state that follows the result
// write, so the input channel is held for the whole update.
// A new beat is taken once the previous result sits in the output register,
// so a slow consumer stalls the next update only after one result is held.
// smoothing_ms resets to 100 and is written through the cfg channel, which is
// always ready; write it only while no update is in flight.
module throttle_exponential_smoother #(
    parameter int FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration write channel
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [15:0]        cfg_smoothing_ms,
    // input beat
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_gas_present,
    input  logic [9:0]         s_gas_level,
    input  logic               s_brake_present,
    input  logic [9:0]         s_brake_level,
    input  logic [15:0]        s_elapsed_ms,
    // result beat
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [11:0] m_drive_pwm,
    output logic               m_active
);

    tes_pkg::tes_cmd_t cmd;
    tes_pkg::tes_sts_t sts;

    // register write is a single flop load, never stalls
    assign cfg_ready = 1'b1;

    tes_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    tes_dpath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dpath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_valid),
        .cfg_smoothing_ms (cfg_smoothing_ms),
        .s_gas_present    (s_gas_present),
        .s_gas_level      (s_gas_level),
        .s_brake_present  (s_brake_present),
        .s_brake_level    (s_brake_level),
        .s_elapsed_ms     (s_elapsed_ms),
        .cmd              (cmd),
        .sts              (sts),
        .m_drive_pwm      (m_drive_pwm),
        .m_active         (m_active)
    );

endmodule
